@@ hdl/dclm_pkg.sv @@
package dclm_pkg;

  localparam int ID_W             = 4;
  localparam int STATUS_W         = 3;
  localparam int THREAD_COUNT_DEF = 16;
  localparam int LOCK_COUNT_DEF   = 16;
  localparam int Q_DEPTH          = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_WAITING  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_BUSY     = 3'd4,
    ST_FREE     = 3'd5
  } status_t;

  typedef struct packed {
    logic            rel;
    logic            bad;
    logic [ID_W-1:0] tid;
    logic [ID_W-1:0] lid;
  } req_t;

endpackage

@@ hdl/deadlock_checked_lock_manager.sv @@
// A grant, busy, refusal or free-lock release is decided in the execute state and its result is registered.
// An acquire of a held lock walks the wait-for chain link by link through S_OWN, S_CHK and S_WL,
// up to THREAD_COUNT links, paced by the single read port of the owner and wait tables.
// A release scans threads in order: an idle thread passes through S_SCAN only, a waiting one also S_SCMP.
// One request is worked at a time, none taken while a result is stalled; a two-beat queue takes input meanwhile.
// Reset (synchronous, rst_n low) clears lock, wait and queue state; no clearing pass.
module deadlock_checked_lock_manager #(
  parameter int THREAD_COUNT = dclm_pkg::THREAD_COUNT_DEF,
  parameter int LOCK_COUNT   = dclm_pkg::LOCK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [dclm_pkg::ID_W-1:0]     in_thread_id,
  input  logic [dclm_pkg::ID_W-1:0]     in_lock_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dclm_pkg::STATUS_W-1:0] out_status,
  output logic                          out_handoff_valid,
  output logic [dclm_pkg::ID_W-1:0]     out_handoff_thread
);
  import dclm_pkg::*;

  logic q_full;
  logic q_push;
  req_t q_push_req;
  logic q_valid;
  req_t q_req;
  logic q_pop;

  dclm_front #(
    .THREAD_COUNT(THREAD_COUNT),
    .LOCK_COUNT  (LOCK_COUNT)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_thread_id(in_thread_id),
    .in_lock_id  (in_lock_id),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_req  (q_push_req)
  );

  dclm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_req(q_push_req),
    .full    (q_full),
    .valid   (q_valid),
    .req     (q_req),
    .pop     (q_pop)
  );

  dclm_back #(
    .THREAD_COUNT(THREAD_COUNT),
    .LOCK_COUNT  (LOCK_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_req             (q_req),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_handoff_valid (out_handoff_valid),
    .out_handoff_thread(out_handoff_thread)
  );

endmodule

@@ hdl/dclm_front.sv @@
module dclm_front #(
  parameter int THREAD_COUNT = dclm_pkg::THREAD_COUNT_DEF,
  parameter int LOCK_COUNT   = dclm_pkg::LOCK_COUNT_DEF
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [dclm_pkg::ID_W-1:0] in_thread_id,
  input  logic [dclm_pkg::ID_W-1:0] in_lock_id,
  input  logic                      q_full,
  output logic                      q_push,
  output dclm_pkg::req_t            q_push_req
);
  import dclm_pkg::*;

  logic tid_bad;
  logic lid_bad;

  assign tid_bad  = int'(in_thread_id) >= THREAD_COUNT;
  assign lid_bad  = int'(in_lock_id) >= LOCK_COUNT;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_req.rel = in_req_type;
    q_push_req.bad = tid_bad || lid_bad;
    q_push_req.tid = in_thread_id;
    q_push_req.lid = in_lock_id;
  end

endmodule

@@ hdl/dclm_queue.sv @@
module dclm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dclm_pkg::req_t push_req,
  output logic           full,
  output logic           valid,
  output dclm_pkg::req_t req,
  input  logic           pop
);
  import dclm_pkg::*;

  localparam int PW   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  req_t            mem [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = count_r == CNTW'(Q_DEPTH);
  assign valid   = count_r != '0;
  assign req     = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/dclm_back.sv @@
module dclm_back #(
  parameter int THREAD_COUNT = dclm_pkg::THREAD_COUNT_DEF,
  parameter int LOCK_COUNT   = dclm_pkg::LOCK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  dclm_pkg::req_t                q_req,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dclm_pkg::STATUS_W-1:0] out_status,
  output logic                          out_handoff_valid,
  output logic [dclm_pkg::ID_W-1:0]     out_handoff_thread
);
  import dclm_pkg::*;

  localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int LW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CW = $clog2(THREAD_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_OWN,
    S_CHK,
    S_WL,
    S_SCAN,
    S_SCMP
  } state_t;

  state_t                  state_r, state_nxt;
  req_t                    req_r, req_nxt;
  logic [TW-1:0]           cur_r, cur_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [LOCK_COUNT-1:0]   held_r, held_nxt;
  logic [THREAD_COUNT-1:0] wait_r, wait_nxt;
  logic                    ov_r, ov_nxt;
  status_t                 ost_r, ost_nxt;
  logic                    ohv_r, ohv_nxt;
  logic [ID_W-1:0]         oht_r, oht_nxt;

  logic [TW-1:0] own_mem [LOCK_COUNT];
  logic [LW-1:0] wl_mem  [THREAD_COUNT];
  logic [TW-1:0] own_q_r;
  logic [LW-1:0] wl_q_r;

  logic          own_we;
  logic [TW-1:0] own_wd;
  logic [LW-1:0] own_ra;
  logic          wl_we;
  logic [TW-1:0] wl_ra;

  logic [TW-1:0] t_idx;
  logic [LW-1:0] l_idx;
  logic [TW-1:0] cnt_idx;
  logic          fin;
  status_t       fin_status;
  logic          fin_hv;
  logic [TW-1:0] fin_ht;
  logic          go_wait;

  assign t_idx   = TW'(req_r.tid);
  assign l_idx   = LW'(req_r.lid);
  assign cnt_idx = cnt_r[TW-1:0];

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    wait_nxt   = wait_r;
    q_pop      = 1'b0;
    own_we     = 1'b0;
    own_wd     = t_idx;
    own_ra     = l_idx;
    wl_we      = 1'b0;
    wl_ra      = cur_r;
    fin        = 1'b0;
    fin_status = ST_REFUSED;
    fin_hv     = 1'b0;
    fin_ht     = '0;
    go_wait    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && (!ov_r || !out_stall)) begin
          q_pop     = 1'b1;
          req_nxt   = q_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cnt_nxt = '0;
        if (req_r.bad) begin
          fin        = 1'b1;
          fin_status = ST_REFUSED;
        end else if (!req_r.rel) begin
          if (wait_r[t_idx]) begin
            fin        = 1'b1;
            fin_status = ST_BUSY;
          end else if (!held_r[l_idx]) begin
            held_nxt[l_idx] = 1'b1;
            own_we          = 1'b1;
            fin             = 1'b1;
            fin_status      = ST_GRANTED;
          end else begin
            state_nxt = S_OWN;
          end
        end else begin
          if (!held_r[l_idx]) begin
            fin        = 1'b1;
            fin_status = ST_FREE;
          end else begin
            held_nxt[l_idx] = 1'b0;
            state_nxt       = S_SCAN;
          end
        end
      end
      S_OWN: begin
        cur_nxt   = own_q_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cnt_r == CW'(THREAD_COUNT)) begin
          go_wait = 1'b1;
        end else if (cur_r == t_idx) begin
          fin        = 1'b1;
          fin_status = ST_REFUSED;
        end else if (!wait_r[cur_r]) begin
          go_wait = 1'b1;
        end else begin
          state_nxt = S_WL;
        end
      end
      S_WL: begin
        if (!held_r[wl_q_r]) begin
          go_wait = 1'b1;
        end else begin
          own_ra    = wl_q_r;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_OWN;
        end
      end
      S_SCAN: begin
        wl_ra = cnt_idx;
        if (cnt_r == CW'(THREAD_COUNT)) begin
          fin        = 1'b1;
          fin_status = ST_RELEASED;
        end else if (!wait_r[cnt_idx]) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (wl_q_r == l_idx) begin
          wait_nxt[cnt_idx] = 1'b0;
          held_nxt[l_idx]   = 1'b1;
          own_we            = 1'b1;
          own_wd            = cnt_idx;
          fin               = 1'b1;
          fin_status        = ST_RELEASED;
          fin_hv            = 1'b1;
          fin_ht            = cnt_idx;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_wait) begin
      wait_nxt[t_idx] = 1'b1;
      wl_we           = 1'b1;
      fin             = 1'b1;
      fin_status      = ST_WAITING;
    end

    ov_nxt  = ov_r && out_stall;
    ost_nxt = ost_r;
    ohv_nxt = ohv_r;
    oht_nxt = oht_r;
    if (fin) begin
      ov_nxt    = 1'b1;
      ost_nxt   = fin_status;
      ohv_nxt   = fin_hv;
      oht_nxt   = ID_W'(fin_ht);
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[l_idx] <= own_wd;
    end
    own_q_r <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (wl_we) begin
      wl_mem[t_idx] <= l_idx;
    end
    wl_q_r <= wl_mem[wl_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      wait_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      wait_r  <= wait_nxt;
      ov_r    <= ov_nxt;
    end
    req_r <= req_nxt;
    cur_r <= cur_nxt;
    cnt_r <= cnt_nxt;
    ost_r <= ost_nxt;
    ohv_r <= ohv_nxt;
    oht_r <= oht_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_handoff_valid  = ohv_r;
  assign out_handoff_thread = oht_r;

endmodule

@@ hdl/dclm_checker.sv @@
module dclm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_req_type,
  input logic [dclm_pkg::ID_W-1:0]     in_thread_id,
  input logic [dclm_pkg::ID_W-1:0]     in_lock_id,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dclm_pkg::STATUS_W-1:0] out_status,
  input logic                          out_handoff_valid,
  input logic [dclm_pkg::ID_W-1:0]     out_handoff_thread
);
  import dclm_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_handoff_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_handoff_valid |-> out_status == ST_RELEASED)
    else $error("hand-off on a beat that is not a release");

  a_no_handoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_handoff_valid |-> out_handoff_thread == '0)
    else $error("hand-off thread set without a hand-off");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_handoff_valid) && $stable(out_handoff_thread))
    else $error("stalled result beat changed");

endmodule

bind deadlock_checked_lock_manager dclm_checker u_dclm_checker (.*);
